// ===== hdl/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg: codec control serializer shared definitions
// Slot kinds, command modes, the decoded command record that travels
// from the front end to the slot sequencer, and the volume-chip channel codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

   // slot kinds on the result channel
   localparam logic [2:0] SLOT_START    = 3'd0;
   localparam logic [2:0] SLOT_BIT      = 3'd1;
   localparam logic [2:0] SLOT_NINTH    = 3'd2;
   localparam logic [2:0] SLOT_STOP     = 3'd3;
   localparam logic [2:0] SLOT_SELECT   = 3'd4;
   localparam logic [2:0] SLOT_DESELECT = 3'd5;
   localparam logic [2:0] SLOT_REJECT   = 3'd6;

   // command modes on the request channel
   localparam logic [1:0] MODE_SPI_WRITE = 2'd0;
   localparam logic [1:0] MODE_DAC_ATT   = 2'd1;
   localparam logic [1:0] MODE_VOL_ATT   = 2'd2;
   localparam logic [1:0] MODE_VOL_BYTE  = 2'd3;

   // decoded command classes
   localparam logic [1:0] CMD_SPI    = 2'd0;
   localparam logic [1:0] CMD_WIRE   = 2'd1;
   localparam logic [1:0] CMD_REJECT = 2'd2;

   // byte values
   localparam logic [2:0] SPI_HDR_TOP   = 3'b101;   // control code 2 and write bit
   localparam logic [7:0] WIRE_ADDR     = 8'h80;
   localparam logic [7:0] VOL_TENS_BIAS = 8'h10;
   localparam logic [4:0] DAC_REG_BASE  = 5'h04;    // channels 0..5
   localparam logic [4:0] DAC_REG_HIGH  = 5'h05;    // channels 6..7 skip register 10
   localparam logic [3:0] DAC_CHAN_SPLIT = 4'd6;
   localparam logic [3:0] VOL_CHAN_MAX  = 4'd5;
   localparam logic signed [7:0] DAC_ATT_MIN = -8'sd127;
   localparam logic signed [7:0] VOL_ATT_MIN = -8'sd79;

   // divide by ten through a reciprocal: exact for values below 1029
   localparam logic [7:0] DIV10_MUL   = 8'd205;
   localparam int         DIV10_SHIFT = 11;

   // last bit position inside a byte, and the position of the dummy slot after it
   localparam logic [3:0] POS_LAST_BIT = 4'd7;
   localparam logic [3:0] POS_NINTH    = 4'd8;

   // command queue between front end and sequencer
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // decoded command
   typedef struct packed {
      logic [1:0] kind;        // CMD_SPI, CMD_WIRE or CMD_REJECT
      logic       dev;         // SPI target: 0 DAC, 1 ADC
      logic [1:0] last_byte;   // index of the final payload byte
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } cmd_type;

   // volume-chip channel code
   function automatic logic [7:0] vol_chan_code(input logic [2:0] ch);
      logic [7:0] code;
      case (ch)
         3'd0:    code = 8'h90;
         3'd1:    code = 8'h50;
         3'd2:    code = 8'h10;
         3'd3:    code = 8'h30;
         3'd4:    code = 8'h70;
         3'd5:    code = 8'hB0;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/codec_control_serializer_top.sv =====
// ----------------------------------------------------------------------------
// codec_control_serializer_top: codec control command serializer
// Turns one codec control command into its ordered serial bus slots.
// ----------------------------------------------------------------------------
// Each accepted command yields a burst of result beats, one slot per cycle
// while rsp_stall is low: 18 beats for an SPI register write or DAC
// attenuation, 29 for a volume-chip attenuation, 20 for a volume-chip byte and
// one for an out-of-range command; rsp_last marks the final beat. The slot
// sequencer, emitting one slot per cycle while rsp_stall is low, sets the
// rate. A two-entry command queue between the classifier and the sequencer
// takes new commands while earlier ones are still being sent; the next command
// starts as soon as the previous one's last slot is taken. Each request
// goes through the queue, cur_ff and the result register to the output.
`default_nettype none

module codec_control_serializer_top
   import ccs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_mode,
   input  wire logic              req_device,
   input  wire logic [4:0]        req_reg_addr,
   input  wire logic [7:0]        req_data,
   input  wire logic [3:0]        req_channel,
   input  wire logic signed [7:0] req_attenuation,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_slot_kind,
   output logic                   rsp_serial_data,
   output logic                   rsp_dac_select_n,
   output logic                   rsp_adc_select_n,
   output logic                   rsp_last
);

   logic    push_valid;
   logic    push_full;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop;
   cmd_type pop_cmd;

   // classify commands
   ccs_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_device      (req_device),
      .req_reg_addr    (req_reg_addr),
      .req_data        (req_data),
      .req_channel     (req_channel),
      .req_attenuation (req_attenuation),
      .push_valid      (push_valid),
      .push_full       (push_full),
      .push_cmd        (push_cmd)
   );

   // decoupling queue
   ccs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   // emit slots
   ccs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (pop_valid),
      .q_cmd            (pop_cmd),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_kind    (rsp_slot_kind),
      .rsp_serial_data  (rsp_serial_data),
      .rsp_dac_select_n (rsp_dac_select_n),
      .rsp_adc_select_n (rsp_adc_select_n),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hdl/ccs_front.sv =====
// ----------------------------------------------------------------------------
// ccs_front: command classifier
// Checks the request fields, builds the header and payload bytes of the
// command and hands the decoded record to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_front
   import ccs_pkg::*;
(
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_mode,
   input  wire logic              req_device,
   input  wire logic [4:0]        req_reg_addr,
   input  wire logic [7:0]        req_data,
   input  wire logic [3:0]        req_channel,
   input  wire logic signed [7:0] req_attenuation,
   output logic                   push_valid,
   input  wire logic              push_full,
   output cmd_type                push_cmd
);

   logic        dac_ok;
   logic        vol_ok;
   logic [7:0]  neg_att;
   logic [6:0]  mag;
   logic [14:0] quot_prod;
   logic [3:0]  quot;
   logic [6:0]  quot_x10;
   logic [3:0]  rem;
   logic [7:0]  code;
   logic [7:0]  tens_byte;
   logic [7:0]  ones_byte;
   logic [4:0]  dac_reg;

   // handshake: accept whenever the queue has room
   assign req_stall  = push_full;
   assign push_valid = req_valid;

   // range checks
   assign dac_ok = !req_channel[3] &&
                   (req_attenuation <= 8'sd0) && (req_attenuation >= DAC_ATT_MIN);
   assign vol_ok = (req_channel <= VOL_CHAN_MAX) &&
                   (req_attenuation <= 8'sd0) && (req_attenuation >= VOL_ATT_MIN);

   // tens and ones of the attenuation magnitude (only used when in range)
   assign neg_att   = 8'(-req_attenuation);
   assign mag       = neg_att[6:0];
   assign quot_prod = 15'(mag) * 15'(DIV10_MUL);
   assign quot      = 4'(quot_prod >> DIV10_SHIFT);
   assign quot_x10  = 7'({quot, 3'b000}) + 7'({quot, 1'b0});
   assign rem       = 4'(mag - quot_x10);

   assign code      = vol_chan_code(req_channel[2:0]);
   assign tens_byte = 8'(quot) + code - VOL_TENS_BIAS;
   assign ones_byte = 8'(rem) + code;

   // DAC channel to register
   assign dac_reg = (req_channel < DAC_CHAN_SPLIT) ? DAC_REG_BASE + 5'(req_channel)
                                                   : DAC_REG_HIGH + 5'(req_channel);

   // build the command record
   always_comb begin
      push_cmd           = '0;
      push_cmd.last_byte = 2'd1;
      case (req_mode)
         MODE_SPI_WRITE: begin
            push_cmd.kind  = CMD_SPI;
            push_cmd.dev   = req_device;
            push_cmd.byte0 = {SPI_HDR_TOP, req_reg_addr};
            push_cmd.byte1 = req_data;
         end
         MODE_DAC_ATT: begin
            push_cmd.kind  = dac_ok ? CMD_SPI : CMD_REJECT;
            push_cmd.dev   = 1'b0;
            push_cmd.byte0 = {SPI_HDR_TOP, dac_reg};
            // 0x80 + att + 127 wraps to att - 1
            push_cmd.byte1 = 8'(req_attenuation) - 8'd1;
         end
         MODE_VOL_ATT: begin
            push_cmd.kind      = vol_ok ? CMD_WIRE : CMD_REJECT;
            push_cmd.last_byte = 2'd2;
            push_cmd.byte0     = WIRE_ADDR;
            push_cmd.byte1     = tens_byte;
            push_cmd.byte2     = ones_byte;
         end
         MODE_VOL_BYTE: begin
            push_cmd.kind  = CMD_WIRE;
            push_cmd.byte0 = WIRE_ADDR;
            push_cmd.byte1 = req_data;
         end
         default: begin
            push_cmd.kind = CMD_REJECT;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/ccs_queue.sv =====
// ----------------------------------------------------------------------------
// ccs_queue: command queue
// Short register queue of decoded commands between the classifier and the
// slot sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_queue
   import ccs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_full,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop,
   output cmd_type      pop_cmd
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;

   assign push_full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QUEUE_CNT_W'(QUEUE_DEPTH)) |->
      wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== hdl/ccs_back.sv =====
// ----------------------------------------------------------------------------
// ccs_back: slot sequencer
// Walks one decoded command slot by slot (head, payload bits, tail) and
// drives the registered result channel, one slot per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_back
   import ccs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [2:0]   rsp_slot_kind,
   output logic         rsp_serial_data,
   output logic         rsp_dac_select_n,
   output logic         rsp_adc_select_n,
   output logic         rsp_last
);

   localparam logic [1:0] STEP_HEAD = 2'd0;
   localparam logic [1:0] STEP_BODY = 2'd1;
   localparam logic [1:0] STEP_TAIL = 2'd2;

   cmd_type    cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] step_ff, step_in;
   logic [3:0] pos_ff, pos_in;
   logic [1:0] byte_ff, byte_in;

   logic       rsp_valid_ff;
   logic [2:0] rsp_kind_ff;
   logic       rsp_sd_ff;
   logic       rsp_dacn_ff;
   logic       rsp_adcn_ff;
   logic       rsp_last_ff;

   logic       out_free;
   logic       advance;
   logic       load;
   logic [7:0] cur_byte;
   logic [2:0] bit_idx;
   logic       bit_val;
   logic       byte_done;
   logic [2:0] slot_kind;
   logic       slot_sd;
   logic       slot_dacn;
   logic       slot_adcn;
   logic       slot_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = out_free && cur_valid_ff;
   assign load     = q_valid && (!cur_valid_ff || (advance && slot_last));
   assign q_pop    = load;

   // current payload byte and bit
   always_comb begin
      case (byte_ff)
         2'd0:    cur_byte = cur_ff.byte0;
         2'd1:    cur_byte = cur_ff.byte1;
         default: cur_byte = cur_ff.byte2;
      endcase
   end
   assign bit_idx   = 3'(POS_LAST_BIT - pos_ff);
   assign bit_val   = cur_byte[bit_idx];
   assign byte_done = (byte_ff == cur_ff.last_byte);

   // slot decode and counter steps
   always_comb begin
      slot_kind = SLOT_REJECT;
      slot_sd   = 1'b0;
      slot_dacn = 1'b1;
      slot_adcn = 1'b1;
      slot_last = 1'b0;
      step_in   = step_ff;
      pos_in    = pos_ff;
      byte_in   = byte_ff;
      case (step_ff)
         STEP_HEAD: begin
            pos_in  = '0;
            byte_in = '0;
            if (cur_ff.kind == CMD_SPI) begin
               slot_kind = SLOT_SELECT;
               slot_dacn = cur_ff.dev;
               slot_adcn = !cur_ff.dev;
               step_in   = STEP_BODY;
            end else if (cur_ff.kind == CMD_WIRE) begin
               slot_kind = SLOT_START;
               step_in   = STEP_BODY;
            end else begin
               slot_kind = SLOT_REJECT;
               slot_last = 1'b1;
            end
         end
         STEP_BODY: begin
            if (cur_ff.kind == CMD_SPI) begin
               slot_dacn = cur_ff.dev;
               slot_adcn = !cur_ff.dev;
            end
            if (cur_ff.kind == CMD_WIRE && pos_ff == POS_NINTH) begin
               // dummy slot after the data bits repeats the byte's LSB
               slot_kind = SLOT_NINTH;
               slot_sd   = cur_byte[0];
            end else begin
               slot_kind = SLOT_BIT;
               slot_sd   = bit_val;
            end
            if ((cur_ff.kind == CMD_SPI && pos_ff == POS_LAST_BIT) ||
                (cur_ff.kind == CMD_WIRE && pos_ff == POS_NINTH)) begin
               pos_in = '0;
               if (byte_done) begin
                  step_in = STEP_TAIL;
               end else begin
                  byte_in = byte_ff + 1'b1;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         STEP_TAIL: begin
            slot_last = 1'b1;
            step_in   = STEP_HEAD;
            if (cur_ff.kind == CMD_SPI) begin
               slot_kind = SLOT_DESELECT;
            end else begin
               slot_kind = SLOT_STOP;
               slot_sd   = 1'b1;
            end
         end
         default: begin
            slot_last = 1'b1;
            step_in   = STEP_HEAD;
         end
      endcase
   end

   // active command tracking
   always_comb begin
      cur_valid_in = cur_valid_ff;
      if (load) begin
         cur_valid_in = 1'b1;
      end else if (advance && slot_last) begin
         cur_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= STEP_HEAD;
         pos_ff       <= '0;
         byte_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         if (load) begin
            step_ff <= STEP_HEAD;
            pos_ff  <= '0;
            byte_ff <= '0;
         end else if (advance) begin
            step_ff <= step_in;
            pos_ff  <= pos_in;
            byte_ff <= byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_cmd;
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= cur_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_kind_ff <= slot_kind;
         rsp_sd_ff   <= slot_sd;
         rsp_dacn_ff <= slot_dacn;
         rsp_adcn_ff <= slot_adcn;
         rsp_last_ff <= slot_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_kind    = rsp_kind_ff;
   assign rsp_serial_data  = rsp_sd_ff;
   assign rsp_dac_select_n = rsp_dacn_ff;
   assign rsp_adc_select_n = rsp_adcn_ff;
   assign rsp_last         = rsp_last_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && step_ff == STEP_BODY |-> pos_ff <= POS_NINTH)
      else $error("bit position out of range");

   a_byte_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && step_ff == STEP_BODY |-> byte_ff <= cur_ff.last_byte)
      else $error("byte index past last payload byte");

   a_select_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == SLOT_SELECT || rsp_kind_ff == SLOT_BIT) &&
      (rsp_dacn_ff == 1'b0 || rsp_adcn_ff == 1'b0) |-> rsp_dacn_ff != rsp_adcn_ff)
      else $error("both chip selects asserted");

   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == SLOT_REJECT |-> rsp_last_ff)
      else $error("rejected slot not marked last");

endmodule

`default_nettype wire

// ===== tb/sv/tb_codec_control_serializer_top.sv =====
// ----------------------------------------------------------------------------
// tb_codec_control_serializer_top: self-checking bench for the codec serializer
// Drives SPI writes, DAC and volume-chip attenuations and volume-chip bytes,
// in range and out of range. Each accepted command is expanded into its bus
// slots, and every result beat is checked in order against them. The sender
// works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_codec_control_serializer_top;
   import ccs_pkg::*;

   // legal attenuation floors and channel counts, kept apart from the design
   localparam int DAC_FLOOR     = -127;
   localparam int VOL_FLOOR     = -79;
   localparam int DAC_CHANNELS  = 8;
   localparam int VOL_CHANNELS  = 6;
   localparam int SPI_REG_SPLIT = 6;
   localparam int RANDOM_ITEMS  = 350;

   // one serial bus slot as seen on the result channel
   typedef struct packed {
      logic [2:0] kind;
      logic       sd;
      logic       dac_n;
      logic       adc_n;
      logic       last;
   } slot_type;

   // expands commands into slots and checks result beats against them
   class slot_scoreboard;
      slot_type expected_slots[$];
      slot_type burst[$];
      int       errors;
      int       slots_checked;
      int       rejects;
      int       mode_count[4];

      function new();
         errors = 0;
         slots_checked = 0;
         rejects = 0;
         foreach (mode_count[i]) mode_count[i] = 0;
      endfunction

      function int pending_count();
         return expected_slots.size();
      endfunction

      function void push_slot(logic [2:0] kind, logic sd, logic dac_n, logic adc_n);
         slot_type s;
         s.kind = kind;
         s.sd = sd;
         s.dac_n = dac_n;
         s.adc_n = adc_n;
         s.last = 1'b0;
         burst.push_back(s);
      endfunction

      // eight data bits, MSB first
      function void push_byte(logic [7:0] b, logic dac_n, logic adc_n);
         for (int i = 7; i >= 0; i--) push_slot(SLOT_BIT, b[i], dac_n, adc_n);
      endfunction

      function void push_spi_write(logic dev, logic [4:0] reg_addr, logic [7:0] value);
         logic [7:0] header;
         header = {3'b101, reg_addr};
         push_slot(SLOT_SELECT, 1'b0, dev, ~dev);
         push_byte(header, dev, ~dev);
         push_byte(value, dev, ~dev);
         push_slot(SLOT_DESELECT, 1'b0, 1'b1, 1'b1);
      endfunction

      // byte on the two-wire bus followed by its dummy slot
      function void push_wire_byte(logic [7:0] b);
         push_byte(b, 1'b1, 1'b1);
         push_slot(SLOT_NINTH, b[0], 1'b1, 1'b1);
      endfunction

      function void note_command(logic [1:0] mode, logic dev, logic [4:0] reg_addr,
                                 logic [7:0] data, logic [3:0] channel,
                                 logic signed [7:0] att);
         int         level;
         int         mag;
         logic [4:0] dac_reg;
         logic [7:0] code;
         logic [7:0] tens;
         logic [7:0] ones;
         level = att;
         burst.delete();
         mode_count[mode]++;
         case (mode)
            MODE_SPI_WRITE: begin
               push_spi_write(dev, reg_addr, data);
            end
            MODE_DAC_ATT: begin
               if (channel >= DAC_CHANNELS || level > 0 || level < DAC_FLOOR) begin
                  push_slot(SLOT_REJECT, 1'b0, 1'b1, 1'b1);
               end else begin
                  // register 10 is skipped for the two upper channels
                  dac_reg = (channel < SPI_REG_SPLIT) ? 5'(4 + channel) : 5'(5 + channel);
                  push_spi_write(1'b0, dac_reg, 8'(8'h80 + level - DAC_FLOOR));
               end
            end
            MODE_VOL_ATT: begin
               if (channel >= VOL_CHANNELS || level > 0 || level < VOL_FLOOR) begin
                  push_slot(SLOT_REJECT, 1'b0, 1'b1, 1'b1);
               end else begin
                  case (channel)
                     4'd0:    code = 8'h90;
                     4'd1:    code = 8'h50;
                     4'd2:    code = 8'h10;
                     4'd3:    code = 8'h30;
                     4'd4:    code = 8'h70;
                     default: code = 8'hB0;
                  endcase
                  mag = -level;
                  tens = 8'(mag / 10 + code - 8'h10);
                  ones = 8'(mag % 10 + code);
                  push_slot(SLOT_START, 1'b0, 1'b1, 1'b1);
                  push_wire_byte(8'h80);
                  push_wire_byte(tens);
                  push_wire_byte(ones);
                  push_slot(SLOT_STOP, 1'b1, 1'b1, 1'b1);
               end
            end
            default: begin
               push_slot(SLOT_START, 1'b0, 1'b1, 1'b1);
               push_wire_byte(8'h80);
               push_wire_byte(data);
               push_slot(SLOT_STOP, 1'b1, 1'b1, 1'b1);
            end
         endcase
         if (burst.size() == 1 && burst[0].kind == SLOT_REJECT) rejects++;
         burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i]) expected_slots.push_back(burst[i]);
      endfunction

      function void fail(string msg);
         errors++;
         $error("%s", msg);
      endfunction

      function void check_slot(slot_type got);
         slot_type want;
         slots_checked++;
         if (expected_slots.size() == 0) begin
            fail($sformatf("unexpected result beat: kind %0d", got.kind));
            return;
         end
         want = expected_slots.pop_front();
         if (got.kind !== want.kind)
            fail($sformatf("slot_kind: expected %0d, actual %0d", want.kind, got.kind));
         if (got.sd !== want.sd)
            fail($sformatf("serial_data: expected %0d, actual %0d", want.sd, got.sd));
         if (got.dac_n !== want.dac_n)
            fail($sformatf("dac_select_n: expected %0d, actual %0d", want.dac_n, got.dac_n));
         if (got.adc_n !== want.adc_n)
            fail($sformatf("adc_select_n: expected %0d, actual %0d", want.adc_n, got.adc_n));
         if (got.last !== want.last)
            fail($sformatf("last: expected %0d, actual %0d", want.last, got.last));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_mode = '0;
   logic              req_device = 1'b0;
   logic [4:0]        req_reg_addr = '0;
   logic [7:0]        req_data = '0;
   logic [3:0]        req_channel = '0;
   logic signed [7:0] req_attenuation = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_slot_kind;
   logic              rsp_serial_data;
   logic              rsp_dac_select_n;
   logic              rsp_adc_select_n;
   logic              rsp_last;

   slot_scoreboard sb;
   int             burst_left = 0;
   int             stall_cycle = 0;

   codec_control_serializer_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_device       (req_device),
      .req_reg_addr     (req_reg_addr),
      .req_data         (req_data),
      .req_channel      (req_channel),
      .req_attenuation  (req_attenuation),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_kind    (rsp_slot_kind),
      .rsp_serial_data  (rsp_serial_data),
      .rsp_dac_select_n (rsp_dac_select_n),
      .rsp_adc_select_n (rsp_adc_select_n),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   // drive one command beat and hold it until the block takes it
   task automatic send_command(input logic [1:0] mode, input logic dev,
                               input logic [4:0] reg_addr, input logic [7:0] data,
                               input logic [3:0] channel, input logic signed [7:0] att);
      @(negedge clock);
      req_mode = mode;
      req_device = dev;
      req_reg_addr = reg_addr;
      req_data = data;
      req_channel = channel;
      req_attenuation = att;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_command(mode, dev, reg_addr, data, channel, att);
   endtask

   // bursts of back-to-back beats separated by idle gaps
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_valid = 1'b0;
         req_data = 8'($urandom);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(0, 11);
      end
   endtask

   // hold off until the result side has drained
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // receiver stall pattern: free running, light, heavy, then periodic
   initial begin
      forever begin
         @(negedge clock);
         stall_cycle++;
         case ((stall_cycle >> 8) % 4)
            0:       rsp_stall = 1'b0;
            1:       rsp_stall = ($urandom_range(0, 3) == 0);
            2:       rsp_stall = ($urandom_range(0, 9) < 7);
            default: rsp_stall = ((stall_cycle % 7) < 3);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_slot({rsp_slot_kind, rsp_serial_data, rsp_dac_select_n,
                        rsp_adc_select_n, rsp_last});
   end

   initial begin
      logic [1:0]        m;
      logic              dv;
      logic [4:0]        ra;
      logic [7:0]        dt;
      logic [3:0]        ch;
      logic signed [7:0] at;
      int                mag;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, every mode, register skip, range edges
      send_command(MODE_SPI_WRITE, 1'b0, 5'd0,  8'h00, 4'($urandom), 8'($urandom));
      pace_sender();
      send_command(MODE_SPI_WRITE, 1'b1, 5'd31, 8'hFF, 4'($urandom), 8'($urandom));
      pace_sender();
      send_command(MODE_SPI_WRITE, 1'b0, 5'h15, 8'hA5, 4'($urandom), 8'($urandom));
      pace_sender();
      send_command(MODE_DAC_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd0, 8'sd0);
      pace_sender();
      send_command(MODE_DAC_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd5, -8'sd127);
      pace_sender();
      send_command(MODE_DAC_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd6, -8'sd64);
      pace_sender();
      send_command(MODE_DAC_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd7, -8'sd1);
      pace_sender();
      send_command(MODE_DAC_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd8, 8'sd0);
      pace_sender();
      send_command(MODE_DAC_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd15, -8'sd10);
      pace_sender();
      send_command(MODE_DAC_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd3, 8'sd1);
      pace_sender();
      send_command(MODE_DAC_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd0, -8'sd128);
      pace_sender();
      send_command(MODE_DAC_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd2, 8'sd127);
      pace_sender();
      send_command(MODE_VOL_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd0, 8'sd0);
      pace_sender();
      send_command(MODE_VOL_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd5, -8'sd79);
      pace_sender();
      send_command(MODE_VOL_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd2, -8'sd40);
      pace_sender();
      send_command(MODE_VOL_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd1, -8'sd9);
      pace_sender();
      send_command(MODE_VOL_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd3, -8'sd10);
      pace_sender();
      send_command(MODE_VOL_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd4, -8'sd80);
      pace_sender();
      send_command(MODE_VOL_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd6, 8'sd0);
      pace_sender();
      send_command(MODE_VOL_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd0, 8'sd5);
      pace_sender();
      send_command(MODE_VOL_ATT, 1'($urandom), 5'($urandom), 8'($urandom), 4'd15, -8'sd128);
      pace_sender();
      send_command(MODE_VOL_BYTE, 1'($urandom), 5'($urandom), 8'h00, 4'($urandom),
                   8'($urandom));
      pace_sender();
      send_command(MODE_VOL_BYTE, 1'($urandom), 5'($urandom), 8'hFF, 4'($urandom),
                   8'($urandom));
      pace_sender();
      send_command(MODE_VOL_BYTE, 1'($urandom), 5'($urandom), 8'h5A, 4'($urandom),
                   8'($urandom));
      pace_sender();
      drain_results();

      // random: mostly legal parameters, some anywhere in the field range
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         m = 2'($urandom_range(0, 3));
         dv = 1'($urandom);
         ra = 5'($urandom);
         dt = 8'($urandom);
         ch = 4'($urandom);
         at = 8'($urandom);
         if (m == MODE_DAC_ATT && $urandom_range(0, 4) != 0) begin
            ch = 4'($urandom_range(0, DAC_CHANNELS - 1));
            mag = $urandom_range(0, -DAC_FLOOR);
            at = 8'(-mag);
         end else if (m == MODE_VOL_ATT && $urandom_range(0, 4) != 0) begin
            ch = 4'($urandom_range(0, VOL_CHANNELS - 1));
            mag = $urandom_range(0, -VOL_FLOOR);
            at = 8'(-mag);
         end
         send_command(m, dv, ra, dt, ch, at);
         pace_sender();
         if (n == RANDOM_ITEMS / 2) drain_results();
      end

      drain_results();
      repeat (40) @(posedge clock);

      $display("Covered %0d commands: %0d SPI writes, %0d DAC, %0d volume att, %0d volume byte",
               sb.mode_count[0] + sb.mode_count[1] + sb.mode_count[2] + sb.mode_count[3],
               sb.mode_count[0], sb.mode_count[1], sb.mode_count[2], sb.mode_count[3]);
      $display("%0d out-of-range commands, %0d result beats checked, %0d mismatches",
               sb.rejects, sb.slots_checked, sb.errors);
      if (sb.errors == 0 && sb.pending_count() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ccs_pkg.sv
hdl/ccs_front.sv
hdl/ccs_queue.sv
hdl/ccs_back.sv
hdl/codec_control_serializer_top.sv
tb/sv/tb_codec_control_serializer_top.sv
